@@ src/pps_pkg.sv @@
// pps_pkg: shared constants, types and helpers of the projection profile segmenter
// depends on nothing; imported by every other file of the block

package pps_pkg;

    // frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field widths
    localparam int PIXEL_W      = 8;
    localparam int THRESHOLD_W  = 8;
    localparam int SIZE_W       = 11;
    localparam int SEG_START_W  = 10;
    localparam int SEG_LENGTH_W = 11;
    localparam int SEG_INDEX_W  = 9;
    localparam int SEGS_W       = 10;

    // derived internal widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int RUN_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (SIZE_W > RUN_W) ? SIZE_W : RUN_W;

    // configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_AXIS_MODE    = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } pps_reg_t;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd128;
    localparam logic                   AXIS_MODE_RESET = 1'b0;
    localparam logic [SIZE_W-1:0]      WIDTH_RESET     = 11'd1024;
    localparam logic [SIZE_W-1:0]      HEIGHT_RESET    = 11'd1024;

    localparam logic AXIS_ROWS = 1'b0;

    typedef struct packed {
        logic [THRESHOLD_W-1:0] threshold;
        logic                   axis_mode;
        logic [SIZE_W-1:0]      image_width;
        logic [SIZE_W-1:0]      image_height;
    } pps_cfg_t;

    // one pixel on its way from the front stage to the run tracker
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_end;
        logic             last_row;
        logic             first_row;
        logic             lt;
        logic             le;
        logic             fwd;
        logic             fwd_val;
    } pps_item_t;

    // dark map write from the run tracker
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic             data;
    } pps_wr_t;

    // zero acts as one, oversize saturates
    function automatic logic [CMP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [CMP_W-1:0] maxv);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0)
            return CMP_W'(1);
        else if (ext > maxv)
            return maxv;
        else
            return ext;
    endfunction

endpackage

@@ src/pps_if.sv @@
// pps_if: valid/ready channel interfaces of the segmenter (pixels, segments, config)
// depends on pps_pkg

interface pps_pixel_if;
    import pps_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface pps_seg_if;
    import pps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SEG_START_W-1:0]  seg_start;
    logic [SEG_LENGTH_W-1:0] seg_length;
    logic [SEG_INDEX_W-1:0]  seg_index;
    modport source (output valid, output seg_start, output seg_length, output seg_index,
                    input ready);
    modport sink   (input valid, input seg_start, input seg_length, input seg_index,
                    output ready);
endinterface

interface pps_cfg_if;
    import pps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/pps_dark_map.sv @@
// pps_dark_map: per-column dark map, one-bit synchronous memory with registered read
// holds the clearing pass after reset; depends on pps_pkg

module pps_dark_map (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [pps_pkg::COL_W-1:0] rd_addr,
    output logic                      rd_data,
    input  pps_pkg::pps_wr_t          wr,
    output logic                      busy
);
    import pps_pkg::*;

    logic             mem [MAX_WIDTH];
    logic             rd_data_reg;
    logic             clr_active_reg, clr_active_next;
    logic [COL_W-1:0] clr_addr_reg, clr_addr_next;
    logic             wr_en_eff;
    logic [COL_W-1:0] wr_addr_eff;
    logic             wr_data_eff;

    // clearing sweep, one entry a cycle
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                clr_active_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // write port shared between sweep and tracker
    always_comb
    begin
        wr_en_eff   = clr_active_reg ? 1'b1 : wr.en;
        wr_addr_eff = clr_active_reg ? clr_addr_reg : wr.addr;
        wr_data_eff = clr_active_reg ? 1'b0 : wr.data;
    end

    // memory array
    always_ff @(posedge clk)
    begin
        if (wr_en_eff)
            mem[wr_addr_eff] <= wr_data_eff;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

@@ src/pps_front.sv @@
// pps_front: pixel acceptance, raster position counters and dark map read issue
// registers each pixel into the tracker stage; depends on pps_pkg, pps_if

module pps_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pps_pkg::pps_cfg_t         cfg,
    pps_pixel_if.sink                 pixels,
    input  logic                      busy,
    input  logic                      s1_advance,
    input  pps_pkg::pps_wr_t          wr,
    output logic                      rd_en,
    output logic [pps_pkg::COL_W-1:0] rd_addr,
    output logic                      item_valid,
    output pps_pkg::pps_item_t        item
);
    import pps_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             s1_valid_reg, s1_valid_next;
    pps_item_t        item_reg, item_next;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;
    logic             accept;
    logic             row_end;
    logic             last_row;

    assign pixels.ready = !busy && (!s1_valid_reg || s1_advance);
    assign accept       = pixels.valid && pixels.ready;

    // position decode
    always_comb
    begin
        width_eff  = clamp_size(cfg.image_width, CMP_W'(MAX_WIDTH));
        height_eff = clamp_size(cfg.image_height, CMP_W'(MAX_HEIGHT));
        row_end    = CMP_W'(col_reg) >= (width_eff - 1'b1);
        last_row   = CMP_W'(row_reg) >= (height_eff - 1'b1);
    end

    // raster advance and stage load
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        s1_valid_next = s1_valid_reg;
        item_next     = item_reg;
        if (s1_advance)
            s1_valid_next = 1'b0;
        if (accept)
        begin
            s1_valid_next      = 1'b1;
            item_next.col      = col_reg;
            item_next.row      = row_reg;
            item_next.row_end  = row_end;
            item_next.last_row = last_row;
            item_next.first_row = (row_reg == '0);
            item_next.lt       = pixels.pixel < cfg.threshold;
            item_next.le       = pixels.pixel <= cfg.threshold;
            // tracker writes this entry in the same cycle as our read
            item_next.fwd      = wr.en && (wr.addr == col_reg);
            item_next.fwd_val  = wr.data;
            if (row_end)
            begin
                col_next = '0;
                if (last_row)
                    row_next = '0;
                else
                    row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign rd_en      = accept;
    assign rd_addr    = col_reg;
    assign item_valid = s1_valid_reg;
    assign item       = item_reg;

endmodule

@@ src/pps_track.sv @@
// pps_track: dark map update, run tracking and the segment output register
// depends on pps_pkg, pps_if

module pps_track (
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::pps_cfg_t  cfg,
    input  logic               item_valid,
    input  pps_pkg::pps_item_t item,
    input  logic               rd_data,
    output logic               s1_advance,
    output pps_pkg::pps_wr_t   wr,
    pps_seg_if.source          segments
);
    import pps_pkg::*;

    logic                    prev_dark_reg, prev_dark_next;
    logic [POS_W-1:0]        run_begin_reg, run_begin_next;
    logic [RUN_W-1:0]        run_count_reg, run_count_next;
    logic [SEGS_W-1:0]       seg_cnt_reg, seg_cnt_next;
    logic                    row_has_ink_reg, row_has_ink_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SEG_START_W-1:0]  out_start_reg;
    logic [SEG_LENGTH_W-1:0] out_length_reg;
    logic [SEG_INDEX_W-1:0]  out_index_reg;

    logic             fire;
    logic             old_dark;
    logic             new_dark;
    logic             ink_row;
    logic             do_track;
    logic             dark;
    logic             prev;
    logic [POS_W-1:0] pos;
    logic             last;
    logic [POS_W-1:0] trk_begin;
    logic [RUN_W-1:0] trk_count;
    logic             trk_emit;

    assign s1_advance = !out_valid_reg || segments.ready;
    assign fire       = item_valid && s1_advance;

    // dark map read-modify-write
    always_comb
    begin
        old_dark = item.fwd ? item.fwd_val : rd_data;
        new_dark = item.first_row ? item.le : (old_dark | item.le);
        wr.en    = fire && (cfg.axis_mode != AXIS_ROWS);
        wr.addr  = item.col;
        wr.data  = new_dark;
    end

    // select what the run tracker sees this pixel
    always_comb
    begin
        ink_row = row_has_ink_reg | item.lt;
        if (cfg.axis_mode != AXIS_ROWS)
        begin
            do_track = item.last_row;
            dark     = new_dark;
            prev     = (item.col == '0) ? 1'b0 : prev_dark_reg;
            pos      = POS_W'(item.col);
            last     = item.row_end;
        end
        else
        begin
            do_track = item.row_end;
            dark     = ink_row;
            prev     = prev_dark_reg;
            pos      = POS_W'(item.row);
            last     = item.last_row;
        end
        trk_begin = (dark && !prev) ? pos : run_begin_reg;
        if (!dark)
            trk_count = run_count_reg;
        else if (prev)
            trk_count = run_count_reg + 1'b1;
        else
            trk_count = RUN_W'(1);
        trk_emit = do_track && (dark ? last : prev);
    end

    // run state update
    always_comb
    begin
        prev_dark_next   = prev_dark_reg;
        run_begin_next   = run_begin_reg;
        run_count_next   = run_count_reg;
        seg_cnt_next     = seg_cnt_reg;
        row_has_ink_next = row_has_ink_reg;
        if (fire)
        begin
            if (cfg.axis_mode == AXIS_ROWS)
                row_has_ink_next = ink_row;
            if (item.row_end)
                row_has_ink_next = 1'b0;
            if (do_track)
            begin
                prev_dark_next = dark;
                run_begin_next = trk_begin;
                run_count_next = trk_count;
            end
            if (trk_emit)
                seg_cnt_next = seg_cnt_reg + 1'b1;
            // end of frame
            if (item.row_end && item.last_row)
            begin
                prev_dark_next = 1'b0;
                run_begin_next = '0;
                run_count_next = '0;
                seg_cnt_next   = '0;
            end
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (segments.ready)
            out_valid_next = 1'b0;
        if (fire && trk_emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_dark_reg   <= 1'b0;
            run_begin_reg   <= '0;
            run_count_reg   <= '0;
            seg_cnt_reg     <= '0;
            row_has_ink_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_dark_reg   <= prev_dark_next;
            run_begin_reg   <= run_begin_next;
            run_count_reg   <= run_count_next;
            seg_cnt_reg     <= seg_cnt_next;
            row_has_ink_reg <= row_has_ink_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // segment payload
    always_ff @(posedge clk)
    begin
        if (fire && trk_emit)
        begin
            out_start_reg  <= SEG_START_W'(trk_begin);
            out_length_reg <= SEG_LENGTH_W'(trk_count);
            out_index_reg  <= SEG_INDEX_W'(seg_cnt_reg);
        end
    end

    assign segments.valid      = out_valid_reg;
    assign segments.seg_start  = out_start_reg;
    assign segments.seg_length = out_length_reg;
    assign segments.seg_index  = out_index_reg;

endmodule

@@ src/projection_profile_segmenter.sv @@
// projection_profile_segmenter: top level, configuration registers and stage wiring
// a segment passes from the closing pixel's transfer through the tracker stage register
// and the segment output register, and can wait in the tracker stage while the output stalls
// throughput: one pixel per cycle through the dark map read-modify-write with write forwarding;
// a stalled segment holds the tracker stage and with it the pixel input
// reset: control state clears at once; the dark map is then cleared one column a cycle,
// all MAX_WIDTH columns, with pixels held off; configuration transfers are taken throughout
// depends on pps_pkg, pps_if, pps_dark_map, pps_front, pps_track

module projection_profile_segmenter (
    input  logic      clk,
    input  logic      rst_n,
    pps_pixel_if.sink pixels,
    pps_seg_if.source segments,
    pps_cfg_if.sink   cfg
);
    import pps_pkg::*;

    pps_cfg_t         cfg_reg, cfg_next;
    pps_item_t        item;
    pps_wr_t          wr;
    logic             item_valid;
    logic             s1_advance;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             rd_data;
    logic             busy;

    assign cfg.ready = 1'b1;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (pps_reg_t'(cfg.index))
                REG_THRESHOLD:    cfg_next.threshold    = THRESHOLD_W'(cfg.data);
                REG_AXIS_MODE:    cfg_next.axis_mode    = cfg.data[0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = SIZE_W'(cfg.data);
                REG_IMAGE_HEIGHT: cfg_next.image_height = SIZE_W'(cfg.data);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= THRESHOLD_RESET;
            cfg_reg.axis_mode    <= AXIS_MODE_RESET;
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixels     (pixels),
        .busy       (busy),
        .s1_advance (s1_advance),
        .wr         (wr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item)
    );

    pps_dark_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .busy    (busy)
    );

    pps_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .rd_data    (rd_data),
        .s1_advance (s1_advance),
        .wr         (wr),
        .segments   (segments)
    );

endmodule

@@ src/pps_checker.sv @@
// pps_checker: port-level assertions of the segmenter and the bind that attaches them
// depends on pps_pkg and projection_profile_segmenter

module pps_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [pps_pkg::SEG_START_W-1:0]  seg_start,
    input logic [pps_pkg::SEG_LENGTH_W-1:0] seg_length,
    input logic [pps_pkg::SEG_INDEX_W-1:0]  seg_index
);
    import pps_pkg::*;

    // a stalled segment stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("segment dropped while stalled");

    // a stalled segment keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(seg_start) && $stable(seg_length)
                                    && $stable(seg_index))
        else $error("segment payload changed while stalled");

    // the clearing pass holds pixels off straight after reset
    a_clear_after_reset: assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> !in_ready)
        else $error("pixel taken before dark map clear");

    // a newly offered segment follows a pixel transfer through the tracker stage register and the output register
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("segment without a closing pixel");

endmodule

bind projection_profile_segmenter pps_checker u_pps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixels.valid),
    .in_ready   (pixels.ready),
    .out_valid  (segments.valid),
    .out_ready  (segments.ready),
    .seg_start  (segments.seg_start),
    .seg_length (segments.seg_length),
    .seg_index  (segments.seg_index)
);

@@ bench/projection_profile_segmenter_tb.sv @@
// projection_profile_segmenter_tb: self-checking bench for the projection profile segmenter
// drives pixel and register transfers, predicts every segment and checks it in order
// depends on pps_pkg, pps_if and the projection_profile_segmenter top level

module projection_profile_segmenter_tb;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 12;

    typedef struct packed {
        logic [SEG_START_W-1:0]  start;
        logic [SEG_LENGTH_W-1:0] length;
        logic [SEG_INDEX_W-1:0]  index;
    } seg_rec_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    pps_pixel_if pixels();
    pps_seg_if   segments();
    pps_cfg_if   cfg();

    projection_profile_segmenter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .segments (segments),
        .cfg      (cfg)
    );

    // register copies, reset values
    logic [THRESHOLD_W-1:0] ink_level    = THRESHOLD_RESET;
    logic                   axis_sel     = AXIS_MODE_RESET;
    logic [SIZE_W-1:0]      frame_width  = WIDTH_RESET;
    logic [SIZE_W-1:0]      frame_height = HEIGHT_RESET;

    // profile state of the frame in progress
    bit          dark_cols [MAX_WIDTH];
    int unsigned col_pos   = 0;
    int unsigned row_pos   = 0;
    bit          row_ink   = 1'b0;
    bit          prev_dark = 1'b0;
    int unsigned run_first = 0;
    int unsigned run_len   = 0;
    int unsigned segs_done = 0;

    seg_rec_t               pending_segments [$];
    logic [PIXEL_W-1:0]     pixel_q [$];
    int unsigned            pixels_queued = 0;
    int unsigned            pixels_taken  = 0;
    int unsigned            fail_count    = 0;
    int unsigned            cycle_count   = 0;

    // handshake bookkeeping for the driver and the receiver
    logic        pix_acc    = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    rx_pattern_t rx_mode    = RX_OPEN;
    int unsigned rx_left    = 0;

    always #6 clk = ~clk;

    // size register as the block sees it
    function automatic int unsigned clip_size(input logic [SIZE_W-1:0] v, input int unsigned lim);
        if (v == '0)
            return 1;
        else if (int'(v) > lim)
            return lim;
        else
            return int'(v);
    endfunction

    // one row or column step of the run tracker
    function automatic void advance_run(input bit dark, input bit prev, input int unsigned pos,
                                        input bit last);
        bit       closes;
        seg_rec_t rec;
        closes = 1'b0;
        if (dark) begin
            if (!prev) begin
                run_first = pos;
                run_len   = 1;
            end
            else begin
                run_len++;
            end
            closes = last;
        end
        else begin
            closes = prev;
        end
        if (closes) begin
            rec.start  = run_first[SEG_START_W-1:0];
            rec.length = run_len[SEG_LENGTH_W-1:0];
            rec.index  = segs_done[SEG_INDEX_W-1:0];
            pending_segments.push_back(rec);
            segs_done = (segs_done + 1) % 1024;
        end
        prev_dark = dark;
    endfunction

    // expected segments caused by one pixel transfer
    function automatic void project_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned w_eff;
        int unsigned h_eff;
        bit          row_end;
        bit          last_row;
        bit          ink;
        bit          prev;
        w_eff    = clip_size(frame_width, MAX_WIDTH);
        h_eff    = clip_size(frame_height, MAX_HEIGHT);
        row_end  = col_pos >= w_eff - 1;
        last_row = row_pos >= h_eff - 1;
        if (axis_sel == AXIS_ROWS) begin
            if (px < ink_level)
                row_ink = 1'b1;
            if (row_end)
                advance_run(row_ink, prev_dark, row_pos, last_row);
        end
        else begin
            ink = px <= ink_level;
            if (row_pos == 0)
                dark_cols[col_pos] = ink;
            else if (ink)
                dark_cols[col_pos] = 1'b1;
            if (last_row) begin
                prev = (col_pos == 0) ? 1'b0 : prev_dark;
                advance_run(dark_cols[col_pos], prev, col_pos, row_end);
            end
        end
        // raster position, frame wrap clears the run state
        if (row_end) begin
            col_pos = 0;
            row_ink = 1'b0;
            if (last_row) begin
                row_pos   = 0;
                prev_dark = 1'b0;
                run_first = 0;
                run_len   = 0;
                segs_done = 0;
            end
            else begin
                row_pos++;
            end
        end
        else begin
            col_pos++;
        end
    endfunction

    // grey value biased towards ink, threshold or background
    function automatic logic [PIXEL_W-1:0] pick_pixel(input int unsigned ink_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < ink_pct)
            return (ink_level == 0) ? 8'd0 : 8'($urandom_range(0, int'(ink_level) - 1));
        else if (roll < ink_pct + 4)
            return ink_level;
        else if (roll < ink_pct + 12)
            return 8'($urandom);
        else
            return (ink_level == 8'hFF) ? 8'hFF : 8'($urandom_range(int'(ink_level) + 1, 255));
    endfunction

    task automatic push_pixel(input logic [PIXEL_W-1:0] px);
        pixel_q.push_back(px);
        pixels_queued++;
    endtask

    // register transfer, only while no pixel is in flight
    task automatic write_reg(input pps_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // wait for every pixel and every segment, then for the pipeline to drain
    task automatic settle();
        do @(posedge clk);
        while (pixels_taken != pixels_queued || pending_segments.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // background pixels up to the end of the current frame
    task automatic finish_frame();
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned left;
        w_eff = clip_size(frame_width, MAX_WIDTH);
        h_eff = clip_size(frame_height, MAX_HEIGHT);
        left  = 0;
        if (col_pos != 0 || row_pos != 0) begin
            left = (col_pos >= w_eff - 1) ? 1 : w_eff - col_pos;
            if (row_pos < h_eff - 1)
                left += (h_eff - 1 - row_pos) * w_eff;
        end
        repeat (left) push_pixel(8'hFF);
    endtask

    // pixel driver: bursts with random gaps
    always @(negedge clk) begin
        if (!pixels.valid || pix_acc) begin
            if (gap_left != 0) begin
                pixels.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (pixel_q.size() != 0) begin
                pixels.valid <= 1'b1;
                pixels.pixel <= pixel_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else begin
                    burst_left <= burst_left - 1;
                end
            end
            else begin
                pixels.valid <= 1'b0;
            end
        end
    end

    // segment receiver: stall pattern picked at random from open, coin, sparse and comb
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_pattern_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end
        else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   segments.ready <= 1'b1;
            RX_COIN:   segments.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: segments.ready <= ($urandom_range(0, 3) == 0);
            default:   segments.ready <= (rx_left % 5 != 0);
        endcase
    end

    // monitor: register copies, prediction and segment check
    always @(posedge clk) begin
        seg_rec_t want;
        if (rst_n) begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_THRESHOLD:    ink_level    = cfg.data[THRESHOLD_W-1:0];
                    REG_AXIS_MODE:    axis_sel     = cfg.data[0];
                    REG_IMAGE_WIDTH:  frame_width  = cfg.data[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT: frame_height = cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (pixels.valid && pixels.ready) begin
                project_pixel(pixels.pixel);
                pixels_taken++;
            end
            if (segments.valid && segments.ready) begin
                if (pending_segments.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected segment: start %0d length %0d index %0d",
                                 segments.seg_start, segments.seg_length, segments.seg_index);
                end
                else begin
                    want = pending_segments.pop_front();
                    if (segments.seg_start !== want.start || segments.seg_length !== want.length
                        || segments.seg_index !== want.index) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("segment mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.start, want.length, want.index, segments.seg_start,
                                     segments.seg_length, segments.seg_index);
                    end
                end
            end
        end
        pix_acc <= pixels.valid && pixels.ready;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // run limit
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial begin
        int unsigned            random_px;
        int unsigned            frame_px;
        int unsigned            ink_pct;
        int unsigned            n;
        logic [THRESHOLD_W-1:0] level;
        logic [SIZE_W-1:0]      dim;
        rst_n          = 1'b0;
        pixels.valid   = 1'b0;
        pixels.pixel   = '0;
        segments.ready = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_THRESHOLD;
        cfg.data       = '0;
        random_px      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, first row left open
        push_pixel(8'd0);   push_pixel(8'd127); push_pixel(8'd128);
        push_pixel(8'd255); push_pixel(8'd1);   push_pixel(8'd200);
        settle();

        // row mode 3x4: open row closes at once, threshold equality is light, dark last row
        write_reg(REG_THRESHOLD, 11'd100);
        write_reg(REG_AXIS_MODE, 11'(AXIS_ROWS));
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd4);
        push_pixel(8'd255);
        push_pixel(8'd200); push_pixel(8'd200); push_pixel(8'd200);
        push_pixel(8'd100); push_pixel(8'd180); push_pixel(8'd100);
        push_pixel(8'd255); push_pixel(8'd99);  push_pixel(8'd255);
        settle();

        // column mode 4x2: equality is ink, run reaching the last column
        write_reg(REG_AXIS_MODE, 11'd1);
        write_reg(REG_IMAGE_WIDTH, 11'd4);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        push_pixel(8'd100); push_pixel(8'd255); push_pixel(8'd0);   push_pixel(8'd200);
        push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd255); push_pixel(8'd100);
        settle();

        // random phases on small frames, settings changed between them
        while (random_px < 300) begin
            if ($urandom_range(0, 1)) begin
                n     = $urandom_range(0, 9);
                level = (n == 0) ? 8'd0 : (n == 1) ? 8'hFF : 8'($urandom);
                write_reg(REG_THRESHOLD, {3'($urandom), level});
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_AXIS_MODE, 11'($urandom));
            if ($urandom_range(0, 1)) begin
                dim = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 10));
                write_reg(REG_IMAGE_WIDTH, dim);
            end
            if ($urandom_range(0, 1)) begin
                dim = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
                write_reg(REG_IMAGE_HEIGHT, dim);
            end
            case ($urandom_range(0, 3))
                0:       ink_pct = 2;
                1:       ink_pct = 6;
                2:       ink_pct = 15;
                default: ink_pct = 35;
            endcase
            frame_px = clip_size(frame_width, MAX_WIDTH) * clip_size(frame_height, MAX_HEIGHT);
            n = frame_px * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0)
                n += $urandom_range(1, frame_px);
            repeat (n) push_pixel(pick_pixel(ink_pct));
            random_px += n;
            settle();
        end

        // oversize width and zero height, every column dark, lowest threshold
        write_reg(REG_AXIS_MODE, 11'd1);
        write_reg(REG_THRESHOLD, 11'd0);
        write_reg(REG_IMAGE_WIDTH, 11'd1500);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        finish_frame();
        repeat (1024) push_pixel(8'd0);
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_segments.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ projection_profile_segmenter.f @@
src/pps_pkg.sv
src/pps_if.sv
src/pps_dark_map.sv
src/pps_front.sv
src/pps_track.sv
src/projection_profile_segmenter.sv
src/pps_checker.sv
bench/projection_profile_segmenter_tb.sv
